/* rtl/bbit_pkg.sv */
// Shared constants, command codes and control/status structs for the image table.
// No dependencies; every rtl module imports this package.
package bbit_pkg;

   localparam int IMAGE_SLOTS     = 64;
   localparam int PLACEMENT_SLOTS = 4096;
   localparam int SLOT_IDX_W      = $clog2(IMAGE_SLOTS);
   localparam int PLACE_IDX_W     = $clog2(PLACEMENT_SLOTS);
   localparam int PLACE_CNT_W     = $clog2(PLACEMENT_SLOTS + 1);

   localparam logic [31:0] BUDGET_RESET = 32'd268435456;

   localparam logic [2:0] CMD_PUT   = 3'd0;
   localparam logic [2:0] CMD_FIND  = 3'd1;
   localparam logic [2:0] CMD_PLACE = 3'd2;
   localparam logic [2:0] CMD_ERASE = 3'd3;
   localparam logic [2:0] CMD_CLEAR = 3'd4;
   localparam logic [2:0] CMD_DROP  = 3'd5;

   // placement sweep modes
   localparam logic [1:0] PM_CLEAR = 2'd0;
   localparam logic [1:0] PM_PURGE = 2'd1;
   localparam logic [1:0] PM_DROP  = 2'd2;
   localparam logic [1:0] PM_FIND  = 2'd3;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] bytes;
      logic [63:0] age;
   } slot_entry_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] image;
      logic [63:0] anchor;
      logic [63:0] age;
   } place_entry_type;

   typedef struct packed {
      logic       s_scan;
      logic       s_load_key;
      logic       s_auto;
      logic       s_drop;
      logic       s_drop_old;
      logic       s_write;
      logic       s_write_old;
      logic       s_clear;
      logic       p_start;
      logic [1:0] p_mode;
      logic       p_insert;
      logic       rsp_load;
      logic       rsp_status;
      logic       rsp_id;
      logic       rsp_bytes;
      logic       busy;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       req_valid;
      logic       bytes_zero;
      logic       over_budget;
      logic       dims_ok;
      logic       rsp_free;
      logic       s_busy;
      logic       match_hit;
      logic       old_hit;
      logic       free_hit;
      logic       fits;
      logic       p_busy;
   } ctl_sts_type;

endpackage

/* rtl/bbit_slots.sv */
// Image slot datapath: slot memory, valid bits, byte accounting, id and age counters.
// Depends on bbit_pkg.
module bbit_slots (
   input  logic                  clock,
   input  logic                  reset,
   input  bbit_pkg::ctl_cmd_type ctl,
   input  logic [31:0]           req_id,
   input  logic [31:0]           req_bytes,
   input  logic [31:0]           budget,
   output logic                  s_busy,
   output logic                  match_hit,
   output logic                  old_hit,
   output logic                  free_hit,
   output logic                  fits,
   output logic [31:0]           key,
   output logic [31:0]           match_bytes,
   output logic [31:0]           victim_id
);
   import bbit_pkg::*;

   slot_entry_type                mem [IMAGE_SLOTS];
   slot_entry_type                rd_ff;
   logic [IMAGE_SLOTS-1:0]        valid_ff;
   logic [SLOT_IDX_W-1:0]         addr_ff;
   logic [SLOT_IDX_W-1:0]         pend_idx_ff;
   logic                          run_ff;
   logic                          pend_ff;
   logic [31:0]                   key_ff;
   logic [31:0]                   next_auto_ff;
   logic [63:0]                   age_ff;
   logic [32:0]                   used_ff;
   logic                          match_hit_ff;
   logic [SLOT_IDX_W-1:0]         match_idx_ff;
   logic [31:0]                   match_bytes_ff;
   logic                          old_hit_ff;
   logic [SLOT_IDX_W-1:0]         old_idx_ff;
   logic [31:0]                   old_id_ff;
   logic [31:0]                   old_bytes_ff;
   logic [63:0]                   old_age_ff;
   logic                          free_hit_ff;
   logic [SLOT_IDX_W-1:0]         free_idx_ff;
   logic [SLOT_IDX_W-1:0]         drop_idx;
   logic [31:0]                   drop_bytes;
   logic [SLOT_IDX_W-1:0]         wr_idx;
   logic                          ev_valid;
   logic                          ev_match;
   logic                          ev_old;
   logic                          ev_free;

   assign drop_idx    = ctl.s_drop_old ? old_idx_ff : match_idx_ff;
   assign drop_bytes  = ctl.s_drop_old ? old_bytes_ff : match_bytes_ff;
   assign victim_id   = ctl.s_drop_old ? old_id_ff : key_ff;
   assign wr_idx      = ctl.s_write_old ? old_idx_ff : free_idx_ff;
   assign s_busy      = run_ff | pend_ff;
   assign match_hit   = match_hit_ff;
   assign old_hit     = old_hit_ff;
   assign free_hit    = free_hit_ff;
   assign key         = key_ff;
   assign match_bytes = match_bytes_ff;
   assign fits        = ({1'b0, used_ff} + {2'b00, req_bytes}) <= {2'b00, budget};

   assign ev_valid = pend_ff & valid_ff[pend_idx_ff];
   assign ev_match = ev_valid & ~match_hit_ff & (rd_ff.id == key_ff);
   assign ev_old   = ev_valid & (~old_hit_ff | (rd_ff.age < old_age_ff));
   assign ev_free  = pend_ff & ~valid_ff[pend_idx_ff] & ~free_hit_ff;

   always_ff @(posedge clock) begin
      if (ctl.s_write) begin
         mem[wr_idx] <= '{id: key_ff, bytes: req_bytes, age: age_ff};
      end
      rd_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         run_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         addr_ff      <= '0;
         next_auto_ff <= 32'd1;
         age_ff       <= '0;
         used_ff      <= '0;
         match_hit_ff <= 1'b0;
         old_hit_ff   <= 1'b0;
         free_hit_ff  <= 1'b0;
      end else begin
         pend_ff <= run_ff;
         if (ctl.s_scan) begin
            run_ff       <= 1'b1;
            addr_ff      <= '0;
            match_hit_ff <= 1'b0;
            old_hit_ff   <= 1'b0;
            free_hit_ff  <= 1'b0;
         end else begin
            if (run_ff) begin
               addr_ff <= addr_ff + SLOT_IDX_W'(1);
               if (addr_ff == SLOT_IDX_W'(IMAGE_SLOTS - 1)) begin
                  run_ff <= 1'b0;
               end
            end
            if (ev_match) match_hit_ff <= 1'b1;
            if (ev_old)   old_hit_ff   <= 1'b1;
            if (ev_free)  free_hit_ff  <= 1'b1;
         end
         if (ctl.s_load_key && ctl.s_auto && req_id == 32'd0) begin
            next_auto_ff <= (next_auto_ff == '1) ? 32'd1 : next_auto_ff + 32'd1;
         end
         if (ctl.s_clear) begin
            valid_ff <= '0;
            used_ff  <= '0;
         end else if (ctl.s_drop) begin
            valid_ff[drop_idx] <= 1'b0;
            used_ff            <= used_ff - {1'b0, drop_bytes};
         end else if (ctl.s_write) begin
            valid_ff[wr_idx] <= 1'b1;
            used_ff          <= used_ff + {1'b0, req_bytes};
            age_ff           <= age_ff + 64'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= addr_ff;
      if (ctl.s_load_key) begin
         key_ff <= (ctl.s_auto && req_id == 32'd0) ? next_auto_ff : req_id;
      end
      if (ev_match) begin
         match_idx_ff   <= pend_idx_ff;
         match_bytes_ff <= rd_ff.bytes;
      end
      if (ev_old) begin
         old_idx_ff   <= pend_idx_ff;
         old_id_ff    <= rd_ff.id;
         old_bytes_ff <= rd_ff.bytes;
         old_age_ff   <= rd_ff.age;
      end
      if (ev_free) begin
         free_idx_ff <= pend_idx_ff;
      end
   end

endmodule

/* rtl/bbit_places.sv */
// Placement queue datapath: placement memory with sweep engine for clear, purge,
// drop and slot search, plus fill count and age counter. Depends on bbit_pkg.
module bbit_places (
   input  logic                  clock,
   input  logic                  reset,
   input  bbit_pkg::ctl_cmd_type ctl,
   input  logic [31:0]           victim_id,
   input  logic [31:0]           key,
   input  logic [63:0]           anchor,
   output logic                  p_busy
);
   import bbit_pkg::*;

   place_entry_type             mem [PLACEMENT_SLOTS];
   place_entry_type             rd_ff;
   logic [PLACE_IDX_W-1:0]      addr_ff;
   logic [PLACE_IDX_W-1:0]      pend_idx_ff;
   logic                        run_ff;
   logic                        pend_ff;
   logic [1:0]                  mode_ff;
   logic [31:0]                 pid_ff;
   logic [63:0]                 line_ff;
   logic [PLACE_CNT_W-1:0]      count_ff;
   logic [63:0]                 age_ff;
   logic                        free_hit_ff;
   logic [PLACE_IDX_W-1:0]      free_idx_ff;
   logic                        old_hit_ff;
   logic [PLACE_IDX_W-1:0]      old_idx_ff;
   logic [63:0]                 old_age_ff;
   logic                        full;
   logic                        ev_kill;
   logic                        ev_free;
   logic                        ev_old;
   logic                        we;
   logic [PLACE_IDX_W-1:0]      wa;
   place_entry_type             wd;

   assign full   = (count_ff == PLACE_CNT_W'(PLACEMENT_SLOTS));
   assign p_busy = run_ff | pend_ff;

   assign ev_kill = pend_ff & rd_ff.valid &
                    (((mode_ff == PM_PURGE) && (rd_ff.image == pid_ff)) ||
                     ((mode_ff == PM_DROP) && (rd_ff.anchor < line_ff)));
   assign ev_free = pend_ff & (mode_ff == PM_FIND) & ~rd_ff.valid & ~free_hit_ff;
   assign ev_old  = pend_ff & (mode_ff == PM_FIND) & rd_ff.valid &
                    (~old_hit_ff | (rd_ff.age < old_age_ff));

   always_comb begin
      we = 1'b0;
      wa = addr_ff;
      wd = '0;
      if (run_ff && mode_ff == PM_CLEAR) begin
         we = 1'b1;
      end else if (ev_kill) begin
         we = 1'b1;
         wa = pend_idx_ff;
      end else if (ctl.p_insert) begin
         we = 1'b1;
         wa = full ? old_idx_ff : free_idx_ff;
         wd = '{valid: 1'b1, image: key, anchor: anchor, age: age_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b1;
         pend_ff     <= 1'b0;
         mode_ff     <= PM_CLEAR;
         addr_ff     <= '0;
         count_ff    <= '0;
         age_ff      <= '0;
         free_hit_ff <= 1'b0;
         old_hit_ff  <= 1'b0;
      end else begin
         pend_ff <= run_ff && mode_ff != PM_CLEAR;
         if (ctl.p_start) begin
            run_ff      <= 1'b1;
            addr_ff     <= '0;
            mode_ff     <= ctl.p_mode;
            free_hit_ff <= 1'b0;
            old_hit_ff  <= 1'b0;
            if (ctl.p_mode == PM_CLEAR) count_ff <= '0;
         end else begin
            if (run_ff) begin
               addr_ff <= addr_ff + PLACE_IDX_W'(1);
               if (addr_ff == PLACE_IDX_W'(PLACEMENT_SLOTS - 1)) begin
                  run_ff <= 1'b0;
               end
            end
            if (ev_free) free_hit_ff <= 1'b1;
            if (ev_old)  old_hit_ff  <= 1'b1;
            if (ev_kill) begin
               count_ff <= count_ff - PLACE_CNT_W'(1);
            end else if (ctl.p_insert) begin
               age_ff <= age_ff + 64'd1;
               if (!full) count_ff <= count_ff + PLACE_CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= addr_ff;
      if (ctl.p_start) begin
         pid_ff  <= victim_id;
         line_ff <= anchor;
      end
      if (ev_free) free_idx_ff <= pend_idx_ff;
      if (ev_old) begin
         old_idx_ff <= pend_idx_ff;
         old_age_ff <= rd_ff.age;
      end
   end

endmodule

/* rtl/bbit_ctrl.sv */
// Command sequencer: decodes a command and steps the slot and placement datapaths.
// Depends on bbit_pkg.
module bbit_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  bbit_pkg::ctl_sts_type sts,
   output bbit_pkg::ctl_cmd_type ctl
);
   import bbit_pkg::*;

   localparam logic [3:0] S_RSTWAIT     = 4'd0;
   localparam logic [3:0] S_IDLE        = 4'd1;
   localparam logic [3:0] S_DECODE      = 4'd2;
   localparam logic [3:0] S_LOOKUP_GO   = 4'd3;
   localparam logic [3:0] S_LOOKUP      = 4'd4;
   localparam logic [3:0] S_FIT_SCAN    = 4'd5;
   localparam logic [3:0] S_FIT_WAIT    = 4'd6;
   localparam logic [3:0] S_PURGE_FIT   = 4'd7;
   localparam logic [3:0] S_PURGE_WRITE = 4'd8;
   localparam logic [3:0] S_PURGE_DONE  = 4'd9;
   localparam logic [3:0] S_PLACE_WAIT  = 4'd10;
   localparam logic [3:0] S_SWEEP_WAIT  = 4'd11;
   localparam logic [3:0] S_RESP        = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       r_status_ff, r_status_in;
   logic       r_id_ff, r_id_in;
   logic       r_bytes_ff, r_bytes_in;

   always_comb begin
      state_in       = state_ff;
      r_status_in    = r_status_ff;
      r_id_in        = r_id_ff;
      r_bytes_in     = r_bytes_ff;
      ctl            = '0;
      ctl.busy       = (state_ff != S_IDLE);
      ctl.rsp_status = r_status_ff;
      ctl.rsp_id     = r_id_ff;
      ctl.rsp_bytes  = r_bytes_ff;
      unique case (state_ff) inside
         S_RSTWAIT: begin
            if (!sts.p_busy) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (sts.req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            r_status_in = 1'b1;
            r_id_in     = 1'b0;
            r_bytes_in  = 1'b0;
            unique case (sts.cmd) inside
               CMD_PUT: begin
                  if (sts.bytes_zero || sts.over_budget) begin
                     state_in = S_RESP;
                  end else begin
                     ctl.s_load_key = 1'b1;
                     ctl.s_auto     = 1'b1;
                     state_in       = S_LOOKUP_GO;
                  end
               end
               CMD_FIND, CMD_PLACE, CMD_ERASE: begin
                  ctl.s_load_key = 1'b1;
                  state_in       = S_LOOKUP_GO;
               end
               CMD_CLEAR: begin
                  ctl.s_clear = 1'b1;
                  ctl.p_start = 1'b1;
                  ctl.p_mode  = PM_CLEAR;
                  state_in    = S_SWEEP_WAIT;
               end
               CMD_DROP: begin
                  ctl.p_start = 1'b1;
                  ctl.p_mode  = PM_DROP;
                  state_in    = S_SWEEP_WAIT;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_LOOKUP_GO: begin
            ctl.s_scan = 1'b1;
            state_in   = S_LOOKUP;
         end
         S_LOOKUP: begin
            if (!sts.s_busy) begin
               unique case (sts.cmd)
                  CMD_PUT: begin
                     if (sts.match_hit) begin
                        ctl.s_drop  = 1'b1;
                        ctl.p_start = 1'b1;
                        ctl.p_mode  = PM_PURGE;
                        state_in    = S_PURGE_FIT;
                     end else begin
                        state_in = S_FIT_SCAN;
                     end
                  end
                  CMD_FIND: begin
                     r_status_in = ~sts.match_hit;
                     r_bytes_in  = sts.match_hit;
                     state_in    = S_RESP;
                  end
                  CMD_ERASE: begin
                     if (sts.match_hit) begin
                        ctl.s_drop  = 1'b1;
                        ctl.p_start = 1'b1;
                        ctl.p_mode  = PM_PURGE;
                        state_in    = S_PURGE_DONE;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  CMD_PLACE: begin
                     if (sts.match_hit && sts.dims_ok) begin
                        ctl.p_start = 1'b1;
                        ctl.p_mode  = PM_FIND;
                        state_in    = S_PLACE_WAIT;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_FIT_SCAN: begin
            ctl.s_scan = 1'b1;
            state_in   = S_FIT_WAIT;
         end
         S_FIT_WAIT: begin
            if (!sts.s_busy) begin
               if (!sts.fits) begin
                  if (sts.old_hit) begin
                     ctl.s_drop     = 1'b1;
                     ctl.s_drop_old = 1'b1;
                     ctl.p_start    = 1'b1;
                     ctl.p_mode     = PM_PURGE;
                     state_in       = S_PURGE_FIT;
                  end else begin
                     state_in = S_RESP;
                  end
               end else if (sts.free_hit) begin
                  ctl.s_write = 1'b1;
                  r_status_in = 1'b0;
                  r_id_in     = 1'b1;
                  state_in    = S_RESP;
               end else begin
                  // every slot used: evict the oldest and reuse its slot
                  ctl.s_drop     = 1'b1;
                  ctl.s_drop_old = 1'b1;
                  ctl.p_start    = 1'b1;
                  ctl.p_mode     = PM_PURGE;
                  state_in       = S_PURGE_WRITE;
               end
            end
         end
         S_PURGE_FIT: begin
            if (!sts.p_busy) state_in = S_FIT_SCAN;
         end
         S_PURGE_WRITE: begin
            if (!sts.p_busy) begin
               ctl.s_write     = 1'b1;
               ctl.s_write_old = 1'b1;
               r_status_in     = 1'b0;
               r_id_in         = 1'b1;
               state_in        = S_RESP;
            end
         end
         S_PURGE_DONE, S_SWEEP_WAIT: begin
            if (!sts.p_busy) begin
               r_status_in = 1'b0;
               state_in    = S_RESP;
            end
         end
         S_PLACE_WAIT: begin
            if (!sts.p_busy) begin
               ctl.p_insert = 1'b1;
               r_status_in  = 1'b0;
               state_in     = S_RESP;
            end
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_RSTWAIT;
         r_status_ff <= 1'b0;
         r_id_ff     <= 1'b0;
         r_bytes_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         r_status_ff <= r_status_in;
         r_id_ff     <= r_id_in;
         r_bytes_ff  <= r_bytes_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_scan_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.s_scan |-> !sts.s_busy) else $error("slot scan started while busy");
   a_sweep_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.p_start |-> !sts.p_busy) else $error("placement sweep started while busy");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!sts.s_busy && !sts.p_busy))
      else $error("datapath busy while idle");
   a_write_slot: assert property (@(posedge clock) disable iff (reset)
      (ctl.s_write && !ctl.s_write_old) |-> sts.free_hit)
      else $error("slot write without a free slot");
`endif

endmodule

/* rtl/byte_budget_image_table.sv */
// Image table under a byte budget with a placement queue; one response per command.
// Commands are handled one at a time. The 4096-entry placement memory is swept
// one entry per cycle. Synchronous reset; after reset a clearing pass over the
// placement memory runs before the first command is taken. Budget writes are
// taken at any time.
module byte_budget_image_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_command,
   input  logic [31:0]        req_image_id,
   input  logic [31:0]        req_byte_size,
   input  logic signed [15:0] req_cols,
   input  logic signed [15:0] req_rows,
   input  logic [63:0]        req_anchor_line,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_status,
   output logic [31:0]        rsp_result_id,
   output logic [31:0]        rsp_found_bytes,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_byte_budget
);
   import bbit_pkg::*;

   ctl_cmd_type        ctl;
   ctl_sts_type        sts;
   logic [31:0]        budget_ff;
   logic [2:0]         cmd_ff;
   logic [31:0]        id_ff;
   logic [31:0]        bytes_ff;
   logic signed [15:0] cols_ff;
   logic signed [15:0] rows_ff;
   logic [63:0]        anchor_ff;
   logic               rsp_valid_ff;
   logic               rsp_status_ff;
   logic [31:0]        rsp_id_ff;
   logic [31:0]        rsp_bytes_ff;
   logic               take;
   logic               s_busy, match_hit, old_hit, free_hit, fits, p_busy;
   logic [31:0]        key, match_bytes, victim_id;

   // hold off new transactions while a command is in flight
   assign req_stall = ctl.busy;
   assign take      = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_id   = rsp_id_ff;
   assign rsp_found_bytes = rsp_bytes_ff;

   always_comb begin
      sts             = '0;
      sts.cmd         = cmd_ff;
      sts.req_valid   = req_valid;
      sts.bytes_zero  = (bytes_ff == 32'd0);
      sts.over_budget = (bytes_ff > budget_ff);
      sts.dims_ok     = (cols_ff > 16'sd0) && (rows_ff > 16'sd0);
      sts.rsp_free    = ~rsp_valid_ff | ~rsp_stall;
      sts.s_busy      = s_busy;
      sts.match_hit   = match_hit;
      sts.old_hit     = old_hit;
      sts.free_hit    = free_hit;
      sts.fits        = fits;
      sts.p_busy      = p_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff    <= BUDGET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) budget_ff <= csr_byte_budget;
         // load a finished result, or drop the one just taken
         if (ctl.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff    <= req_command;
         id_ff     <= req_image_id;
         bytes_ff  <= req_byte_size;
         cols_ff   <= req_cols;
         rows_ff   <= req_rows;
         anchor_ff <= req_anchor_line;
      end
      if (ctl.rsp_load) begin
         rsp_status_ff <= ctl.rsp_status;
         rsp_id_ff     <= ctl.rsp_id ? key : 32'd0;
         rsp_bytes_ff  <= ctl.rsp_bytes ? match_bytes : 32'd0;
      end
   end

   bbit_slots u_slots (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .req_id      (id_ff),
      .req_bytes   (bytes_ff),
      .budget      (budget_ff),
      .s_busy      (s_busy),
      .match_hit   (match_hit),
      .old_hit     (old_hit),
      .free_hit    (free_hit),
      .fits        (fits),
      .key         (key),
      .match_bytes (match_bytes),
      .victim_id   (victim_id)
   );

   bbit_places u_places (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .victim_id (victim_id),
      .key       (key),
      .anchor    (anchor_ff),
      .p_busy    (p_busy)
   );

   bbit_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctl   (ctl)
   );

endmodule

/* bench/bbit_checker.sv */
// Checker for the image table: watches the command, response and budget channels,
// predicts each response and compares it. Depends on bbit_pkg only.
`timescale 1ns / 1ps
module bbit_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_command,
   input  logic [31:0]        req_image_id,
   input  logic [31:0]        req_byte_size,
   input  logic signed [15:0] req_cols,
   input  logic signed [15:0] req_rows,
   input  logic [63:0]        req_anchor_line,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_status,
   input  logic [31:0]        rsp_result_id,
   input  logic [31:0]        rsp_found_bytes,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [31:0]        csr_byte_budget,
   output int                 failures,
   output int                 pending,
   output int                 commands_seen,
   output int                 responses_seen
);
   import bbit_pkg::*;

   typedef struct {
      logic        status;
      logic [31:0] result_id;
      logic [31:0] found_bytes;
   } answer_type;

   answer_type answers_due[$];

   logic [31:0]     budget;
   logic            img_on    [IMAGE_SLOTS];
   logic [31:0]     img_tag   [IMAGE_SLOTS];
   logic [31:0]     img_size  [IMAGE_SLOTS];
   logic [63:0]     img_stamp [IMAGE_SLOTS];
   longint unsigned bytes_held;
   logic [63:0]     img_stamp_next;
   logic [31:0]     auto_id;

   logic            pl_on     [PLACEMENT_SLOTS];
   logic [31:0]     pl_image  [PLACEMENT_SLOTS];
   logic [63:0]     pl_anchor [PLACEMENT_SLOTS];
   logic [63:0]     pl_stamp  [PLACEMENT_SLOTS];
   int              pl_count;
   logic [63:0]     pl_stamp_next;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
      failures++;
   endtask

   function automatic int slot_of(input logic [31:0] id);
      for (int i = 0; i < IMAGE_SLOTS; i++)
         if (img_on[i] && img_tag[i] == id) return i;
      return -1;
   endfunction

   function automatic int oldest_image();
      int best;
      best = -1;
      for (int i = 0; i < IMAGE_SLOTS; i++)
         if (img_on[i] && (best < 0 || img_stamp[i] < img_stamp[best])) best = i;
      return best;
   endfunction

   function automatic int free_image();
      for (int i = 0; i < IMAGE_SLOTS; i++)
         if (!img_on[i]) return i;
      return -1;
   endfunction

   // evict one image together with every placement that points at it
   task automatic evict(input int s);
      bytes_held -= img_size[s];
      img_on[s] = 1'b0;
      for (int i = 0; i < PLACEMENT_SLOTS; i++)
         if (pl_on[i] && pl_image[i] == img_tag[s]) begin
            pl_on[i] = 1'b0;
            pl_count--;
         end
   endtask

   task automatic store_image(input logic [31:0] id_in, input logic [31:0] size,
                              inout answer_type ans);
      logic [31:0] id;
      int          s;
      id = id_in;
      if (size == 0 || size > budget) begin
         ans.status = 1'b1;
         return;
      end
      if (id == 0) begin
         id = auto_id;
         auto_id = (auto_id == 32'hFFFF_FFFF) ? 32'd1 : auto_id + 32'd1;
      end
      s = slot_of(id);
      if (s >= 0) evict(s);
      while (bytes_held + size > budget) begin
         s = oldest_image();
         if (s < 0) break;
         evict(s);
      end
      if (bytes_held + size > budget) begin
         ans.status = 1'b1;
         return;
      end
      s = free_image();
      if (s < 0) begin
         evict(oldest_image());
         s = free_image();
      end
      img_on[s]    = 1'b1;
      img_tag[s]   = id;
      img_size[s]  = size;
      img_stamp[s] = img_stamp_next;
      img_stamp_next++;
      bytes_held += size;
      ans.result_id = id;
   endtask

   task automatic add_placement(inout answer_type ans);
      int best, i;
      best = -1;
      if (slot_of(req_image_id) < 0 || req_cols <= 16'sd0 || req_rows <= 16'sd0) begin
         ans.status = 1'b1;
         return;
      end
      // full queue: drop the oldest placement first
      if (pl_count >= PLACEMENT_SLOTS) begin
         for (i = 0; i < PLACEMENT_SLOTS; i++)
            if (pl_on[i] && (best < 0 || pl_stamp[i] < pl_stamp[best])) best = i;
         if (best >= 0) begin
            pl_on[best] = 1'b0;
            pl_count--;
         end
      end
      for (i = 0; i < PLACEMENT_SLOTS; i++)
         if (!pl_on[i]) break;
      pl_image[i]  = req_image_id;
      pl_anchor[i] = req_anchor_line;
      pl_stamp[i]  = pl_stamp_next;
      pl_stamp_next++;
      pl_on[i] = 1'b1;
      pl_count++;
   endtask

   task automatic predict_response();
      answer_type ans;
      int         s;
      ans = '{1'b0, 32'd0, 32'd0};
      case (req_command)
         CMD_PUT:   store_image(req_image_id, req_byte_size, ans);
         CMD_FIND: begin
            s = slot_of(req_image_id);
            if (s < 0) ans.status = 1'b1;
            else ans.found_bytes = img_size[s];
         end
         CMD_PLACE: add_placement(ans);
         CMD_ERASE: begin
            s = slot_of(req_image_id);
            if (s < 0) ans.status = 1'b1;
            else evict(s);
         end
         CMD_CLEAR: begin
            for (int i = 0; i < IMAGE_SLOTS; i++) img_on[i] = 1'b0;
            for (int i = 0; i < PLACEMENT_SLOTS; i++) pl_on[i] = 1'b0;
            pl_count = 0;
            bytes_held = 0;
         end
         CMD_DROP: begin
            for (int i = 0; i < PLACEMENT_SLOTS; i++)
               if (pl_on[i] && pl_anchor[i] < req_anchor_line) begin
                  pl_on[i] = 1'b0;
                  pl_count--;
               end
         end
         default: ans.status = 1'b1;
      endcase
      answers_due = {answers_due, ans};
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         budget         = BUDGET_RESET;
         bytes_held     = 0;
         img_stamp_next = 64'd0;
         auto_id        = 32'd1;
         pl_count       = 0;
         pl_stamp_next  = 64'd0;
         for (int i = 0; i < IMAGE_SLOTS; i++) img_on[i] = 1'b0;
         for (int i = 0; i < PLACEMENT_SLOTS; i++) pl_on[i] = 1'b0;
         answers_due.delete();
         failures       = 0;
         commands_seen  = 0;
         responses_seen = 0;
      end else begin
         if (csr_valid && csr_ready) budget = csr_byte_budget;
         if (req_valid && !req_stall) begin
            predict_response();
            commands_seen++;
         end
         if (rsp_valid && !rsp_stall) begin
            responses_seen++;
            if (answers_due.size() == 0) begin
               report("response with nothing outstanding, responses vs commands",
                      32'(responses_seen), 32'(commands_seen));
            end else begin
               want = answers_due.pop_front();
               if (rsp_status !== want.status)
                  report("status", 32'(rsp_status), 32'(want.status));
               if (rsp_result_id !== want.result_id)
                  report("result_id", rsp_result_id, want.result_id);
               if (rsp_found_bytes !== want.found_bytes)
                  report("found_bytes", rsp_found_bytes, want.found_bytes);
            end
         end
      end
      pending = answers_due.size();
   end

endmodule

/* bench/byte_budget_image_table_test.sv */
// Top of the image table bench: clock, reset, command stimulus, budget writes and verdict.
// Depends on bbit_pkg, byte_budget_image_table and bbit_checker.
`timescale 1ns / 1ps
module byte_budget_image_table_test;
   import bbit_pkg::*;

   // command codes the block does not define; both must be refused
   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_command = CMD_FIND;
   logic [31:0]        req_image_id = '0;
   logic [31:0]        req_byte_size = '0;
   logic signed [15:0] req_cols = '0;
   logic signed [15:0] req_rows = '0;
   logic [63:0]        req_anchor_line = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_status;
   logic [31:0]        rsp_result_id;
   logic [31:0]        rsp_found_bytes;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [31:0]        csr_byte_budget = '0;

   int failures, pending, commands_seen, responses_seen;

   // idle and stall odds in percent, changed per phase
   int          send_idle_pct  = 0;
   int          stall_pct      = 0;
   logic        hold_off_arm   = 1'b0;
   logic [31:0] budget_now     = BUDGET_RESET;

   always #4 clock = ~clock;

   byte_budget_image_table u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_image_id    (req_image_id),
      .req_byte_size   (req_byte_size),
      .req_cols        (req_cols),
      .req_rows        (req_rows),
      .req_anchor_line (req_anchor_line),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_result_id   (rsp_result_id),
      .rsp_found_bytes (rsp_found_bytes),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_byte_budget (csr_byte_budget)
   );

   bbit_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_image_id    (req_image_id),
      .req_byte_size   (req_byte_size),
      .req_cols        (req_cols),
      .req_rows        (req_rows),
      .req_anchor_line (req_anchor_line),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_result_id   (rsp_result_id),
      .rsp_found_bytes (rsp_found_bytes),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_byte_budget (csr_byte_budget),
      .failures        (failures),
      .pending         (pending),
      .commands_seen   (commands_seen),
      .responses_seen  (responses_seen)
   );

   // Receiver side: random stall, plus one long hold-off counted here so the
   // block backs up and stalls its command input while the sender keeps going.
   int   hold_left = 0;
   logic hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_arm && !hold_done) begin
         hold_left = 3000;
         hold_done = 1'b1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Offer one transaction; return at the edge where it was taken. An idle gap
   // lowers valid first, so valid never drops and rises within one edge.
   task automatic send(input logic [2:0] cmd, input logic [31:0] id, input logic [31:0] size,
                       input logic [15:0] cols, input logic [15:0] rows,
                       input logic [63:0] line);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_image_id    <= id;
      req_byte_size   <= size;
      req_cols        <= cols;
      req_rows        <= rows;
      req_anchor_line <= line;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drain every outstanding response, then let the block go quiet.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_budget(input logic [31:0] value);
      drain();
      csr_valid       <= 1'b1;
      csr_byte_budget <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      budget_now = value;
   endtask

   // Random command: mostly a small id pool so puts, finds and places hit,
   // with full-width values mixed in to toggle every field bit.
   task automatic random_command();
      logic [2:0]  cmd;
      logic [31:0] id, size;
      logic [15:0] cols, rows;
      logic [63:0] line;
      int          pick;
      longint unsigned cap;
      pick = $urandom_range(99);
      if (pick < 38) cmd = CMD_PUT;
      else if (pick < 56) cmd = CMD_FIND;
      else if (pick < 78) cmd = CMD_PLACE;
      else if (pick < 86) cmd = CMD_ERASE;
      else if (pick < 89) cmd = CMD_CLEAR;
      else if (pick < 95) cmd = CMD_DROP;
      else cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      pick = $urandom_range(99);
      if (pick < 80) id = $urandom_range(1, 10);
      else if (pick < 90) id = '0;
      else id = $urandom;
      cap = budget_now / 3 + 1;
      pick = $urandom_range(99);
      if (pick < 70) size = 32'(longint'($urandom) % cap + 1);
      else if (pick < 80) size = '0;
      else size = $urandom;
      cols = ($urandom_range(99) < 80) ? 16'($urandom_range(1, 200)) : 16'($urandom);
      rows = ($urandom_range(99) < 80) ? 16'($urandom_range(1, 200)) : 16'($urandom);
      line = ($urandom_range(99) < 70) ? 64'($urandom_range(0, 1000)) : {$urandom, $urandom};
      send(cmd, id, size, cols, rows, line);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: refusals, automatic id, extremes of every field
      send(CMD_PUT,   32'd5,        32'd0,        16'd1, 16'd1, 64'd0);
      send(CMD_PUT,   32'd0,        32'd100,      16'd0, 16'd0, 64'd0);
      send(CMD_PUT,   32'hFFFF_FFFF, 32'd300,     16'd0, 16'd0, 64'd0);
      send(CMD_PUT,   32'd7,        BUDGET_RESET + 32'd1, 16'd0, 16'd0, 64'd0);
      send(CMD_PUT,   32'd8,        BUDGET_RESET, 16'd0, 16'd0, 64'd0);
      send(CMD_FIND,  32'd5,        32'd0,        16'd0, 16'd0, 64'd0);
      send(CMD_FIND,  32'd8,        32'd0,        16'd0, 16'd0, 64'd0);
      send(CMD_PUT,   32'd0,        32'd40,       16'd0, 16'd0, 64'd0);
      send(CMD_PLACE, 32'd2,        32'd0,        16'd3, 16'd2, 64'd10);
      send(CMD_PLACE, 32'd2,        32'd0,        16'h7FFF, 16'h7FFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send(CMD_PLACE, 32'd2,        32'd0,        16'd0, 16'd4, 64'd5);
      send(CMD_PLACE, 32'd2,        32'd0,        16'd4, 16'h8000, 64'd5);
      send(CMD_PLACE, 32'd2,        32'd0,        16'hFFFF, 16'd1, 64'd5);
      send(CMD_PLACE, 32'd99,       32'd0,        16'd1, 16'd1, 64'd5);
      send(CMD_DROP,  32'd0,        32'd0,        16'd0, 16'd0, 64'd11);
      send(CMD_ERASE, 32'd2,        32'd0,        16'd0, 16'd0, 64'd0);
      send(CMD_ERASE, 32'd2,        32'd0,        16'd0, 16'd0, 64'd0);
      send(CMD_PUT,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 16'd0, 64'd0);
      send(CMD_PUT,   32'hFFFF_FFFF, 32'd500,     16'd0, 16'd0, 64'd0);
      send(CMD_CLEAR, 32'd0,        32'd0,        16'd0, 16'd0, 64'd0);
      send(CMD_SPARE_LO, 32'd1,     32'd1,        16'd1, 16'd1, 64'd1);
      send(CMD_SPARE_HI, 32'd1,     32'd1,        16'd1, 16'd1, 64'd1);

      // fill every slot so the next new image pushes out the oldest
      for (int i = 0; i < IMAGE_SLOTS + 2; i++)
         send(CMD_PUT, 32'(1000 + i), 32'd1, 16'd0, 16'd0, 64'd0);
      send(CMD_FIND, 32'd1000, 32'd0, 16'd0, 16'd0, 64'd0);

      // budget extremes: a budget of one byte, then the full 32-bit range
      write_budget(32'd1);
      send(CMD_PUT, 32'd3, 32'd2, 16'd0, 16'd0, 64'd0);
      send(CMD_PUT, 32'd3, 32'd1, 16'd0, 16'd0, 64'd0);
      write_budget(32'hFFFF_FFFF);
      send(CMD_PUT, 32'd4, 32'hFFFF_FFFF, 16'd0, 16'd0, 64'd0);
      send(CMD_PUT, 32'd5, 32'd1, 16'd0, 16'd0, 64'd0);

      // random phases; each lowers or raises the budget and changes the idling
      write_budget(32'd1000);
      send_idle_pct = 0;  stall_pct = 0;
      repeat (12) random_command();
      write_budget(32'd5000);
      send_idle_pct = 86; stall_pct = 0;
      repeat (12) random_command();
      write_budget(32'd300);
      send_idle_pct = 0;  stall_pct = 86;
      hold_off_arm <= 1'b1;
      repeat (12) random_command();
      write_budget(32'hFFFF_FFFF);
      send_idle_pct = 36; stall_pct = 36;
      repeat (12) random_command();

      drain();
      repeat (4200) @(posedge clock);
      $display("covered %0d commands and %0d responses over four budgets and idle mixes",
               commands_seen, responses_seen);
      $display("including slot overflow, budget extremes and a long response hold-off");
      if (failures == 0 && pending == 0)
         $display("byte_budget_image_table regression: pass");
      else
         $display("byte_budget_image_table regression: fail");
      $finish;
   end

   // watchdog well beyond the slowest legal run
   initial begin
      #200_000_000;
      $display("byte_budget_image_table regression: fail");
      $finish;
   end

endmodule
